>>> design/ald_pkg.sv
// Shared types, register codes, key codes and helpers of the key-ladder debouncer.
`timescale 1ns / 1ps
`default_nettype none
package ald_pkg;

    localparam int SAMPLE_W            = 8;
    localparam int SAMPLES_PER_CHANNEL = 5;
    localparam int SUM_W               = SAMPLE_W + $clog2(SAMPLES_PER_CHANNEL);
    localparam int KEY_W               = 4;
    localparam int PERIOD_W            = 16;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 8;

    // Average by scaled reciprocal: the shift keeps the truncated quotient exact
    // over the whole sum range
    localparam int AVG_SHIFT  = SAMPLE_W + 2 * $clog2(SAMPLES_PER_CHANNEL);
    localparam int AVG_RECIP  = (2 ** AVG_SHIFT + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LEVEL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_UPPER     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_MIDDLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_LOWER     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HALF      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_PERIOD = 3'd6;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_NONE     = 4'd0;
    localparam logic [KEY_W-1:0] KEY_A_HIGH   = 4'd1;
    localparam logic [KEY_W-1:0] KEY_B_HIGH   = 4'd2;
    localparam logic [KEY_W-1:0] KEY_A_UPPER  = 4'd3;
    localparam logic [KEY_W-1:0] KEY_B_UPPER  = 4'd4;
    localparam logic [KEY_W-1:0] KEY_A_MIDDLE = 4'd5;
    localparam logic [KEY_W-1:0] KEY_B_MIDDLE = 4'd6;
    localparam logic [KEY_W-1:0] KEY_A_LOWER  = 4'd7;
    localparam logic [KEY_W-1:0] KEY_B_LOWER  = 4'd8;

    // Register reset values
    localparam logic [7:0] RST_HIGH_LEVEL       = 8'd220;
    localparam logic [7:0] RST_CENTER_UPPER     = 8'd130;
    localparam logic [7:0] RST_CENTER_MIDDLE    = 8'd80;
    localparam logic [7:0] RST_CENTER_LOWER     = 8'd60;
    localparam logic [6:0] RST_WINDOW_HALF      = 7'd10;
    localparam logic [7:0] RST_HOLD_LIMIT       = 8'd25;
    localparam logic [7:0] RST_TICKS_PER_PERIOD = 8'd4;

    typedef struct packed {
        logic [7:0] high_level;
        logic [7:0] center_upper;
        logic [7:0] center_middle;
        logic [7:0] center_lower;
        logic [6:0] window_half;
        logic [7:0] hold_limit;
        logic [7:0] ticks_per_period;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a0;
        logic [SAMPLE_W-1:0] sample_a1;
        logic [SAMPLE_W-1:0] sample_a2;
        logic [SAMPLE_W-1:0] sample_a3;
        logic [SAMPLE_W-1:0] sample_a4;
        logic [SAMPLE_W-1:0] sample_b0;
        logic [SAMPLE_W-1:0] sample_b1;
        logic [SAMPLE_W-1:0] sample_b2;
        logic [SAMPLE_W-1:0] sample_b3;
        logic [SAMPLE_W-1:0] sample_b4;
        logic                conversion_done;
    } sample_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key_code;
        logic [PERIOD_W-1:0] elapsed_periods;
    } result_t;

    // What one channel lane found in its average
    typedef struct packed {
        logic above_high;
        logic in_upper;
        logic in_middle;
        logic in_lower;
    } lane_flags_t;

    // Strict window test, bounds taken without wrapping
    function automatic logic in_window(input logic [7:0] avg, input logic [7:0] center,
                                       input logic [6:0] half);
        logic [8:0] upper_bound;
        logic [8:0] avg_plus;
        upper_bound = {1'b0, center} + {2'b00, half};
        avg_plus    = {1'b0, avg} + {2'b00, half};
        return ({1'b0, avg} < upper_bound) && (avg_plus > {1'b0, center});
    endfunction

endpackage
`default_nettype wire

>>> design/ald_lane.sv
// One channel lane: average the samples and register the threshold and window hits.
`timescale 1ns / 1ps
`default_nettype none
module ald_lane
    import ald_pkg::*;
(
    input  wire logic                                          clk,
    input  wire logic                                          load,
    input  wire logic [SAMPLES_PER_CHANNEL-1:0][SAMPLE_W-1:0]  samples,
    input  wire cfg_t                                          cfg,
    output lane_flags_t                                        flags
);

    logic [SUM_W-1:0]      sum;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SAMPLE_W-1:0]   avg;
    lane_flags_t           flags_next;
    lane_flags_t           flags_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SAMPLES_PER_CHANNEL; i++)
        begin
            sum = sum + SUM_W'(samples[i]);
        end
    end

    // Divide by the fixed sample count through a scaled reciprocal, truncating
    assign avg_prod = AVG_PROD_W'(sum) * AVG_PROD_W'(AVG_RECIP);
    assign avg      = avg_prod[AVG_SHIFT +: SAMPLE_W];

    always_comb
    begin
        flags_next.above_high = avg > cfg.high_level;
        flags_next.in_upper   = in_window(avg, cfg.center_upper, cfg.window_half);
        flags_next.in_middle  = in_window(avg, cfg.center_middle, cfg.window_half);
        flags_next.in_lower   = in_window(avg, cfg.center_lower, cfg.window_half);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
`default_nettype wire

>>> design/ald_merge.sv
// Merge stage: classify lane hits into a key, debounce it and count tick periods.
`timescale 1ns / 1ps
`default_nettype none
module ald_merge
    import ald_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        conversion_done,
    input  wire lane_flags_t flags_a,
    input  wire lane_flags_t flags_b,
    input  wire cfg_t        cfg,
    output result_t          result_next
);

    logic [7:0]          tick_phase_reg;
    logic [7:0]          tick_phase_next;
    logic [PERIOD_W-1:0] period_count_reg;
    logic [PERIOD_W-1:0] period_count_next;
    logic [KEY_W-1:0]    previous_index_reg;
    logic [KEY_W-1:0]    previous_index_next;
    logic [7:0]          debounce_count_reg;
    logic [7:0]          debounce_count_next;
    logic [KEY_W-1:0]    reported_key_reg;
    logic [KEY_W-1:0]    reported_key_next;
    logic [KEY_W-1:0]    key;
    logic [7:0]          count;
    logic [7:0]          phase_inc;

    // Later checks override earlier ones
    always_comb
    begin
        key = KEY_NONE;
        if (flags_a.above_high) key = KEY_A_HIGH;
        if (flags_b.above_high) key = KEY_B_HIGH;
        if (flags_a.in_upper)   key = KEY_A_UPPER;
        if (flags_b.in_upper)   key = KEY_B_UPPER;
        if (flags_a.in_middle)  key = KEY_A_MIDDLE;
        if (flags_b.in_middle)  key = KEY_B_MIDDLE;
        if (flags_a.in_lower)   key = KEY_A_LOWER;
        if (flags_b.in_lower)   key = KEY_B_LOWER;
    end

    always_comb
    begin
        phase_inc = tick_phase_reg + 8'd1;
        if (phase_inc == cfg.ticks_per_period)
        begin
            tick_phase_next   = '0;
            period_count_next = period_count_reg + PERIOD_W'(1);
        end
        else
        begin
            tick_phase_next   = phase_inc;
            period_count_next = period_count_reg;
        end
    end

    always_comb
    begin
        previous_index_next = previous_index_reg;
        debounce_count_next = debounce_count_reg;
        reported_key_next   = reported_key_reg;
        count               = debounce_count_reg;
        if (conversion_done)
        begin
            if (key != previous_index_reg)
            begin
                count               = '0;
                previous_index_next = key;
            end
            if (key != KEY_NONE)
            begin
                if (count != 8'hFF)
                begin
                    count = count + 8'd1;
                end
            end
            else if (count != 8'd0)
            begin
                count = count - 8'd1;
            end
            if (count > cfg.hold_limit)
            begin
                debounce_count_next = cfg.hold_limit;
                reported_key_next   = key;
            end
            else
            begin
                debounce_count_next = count;
                reported_key_next   = KEY_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_phase_reg     <= '0;
            period_count_reg   <= '0;
            previous_index_reg <= KEY_NONE;
            debounce_count_reg <= '0;
            reported_key_reg   <= KEY_NONE;
        end
        else if (advance)
        begin
            tick_phase_reg     <= tick_phase_next;
            period_count_reg   <= period_count_next;
            previous_index_reg <= previous_index_next;
            debounce_count_reg <= debounce_count_next;
            reported_key_reg   <= reported_key_next;
        end
    end

    assign result_next.key_code        = reported_key_next;
    assign result_next.elapsed_periods = period_count_next;

endmodule
`default_nettype wire

>>> design/analog_ladder_key_debouncer.sv
// Top level of the analog key-ladder decoder with debounce.
// Usage:
//   sample channel : one transfer per scan tick, carrying five samples of ladder
//                    channel A, five of channel B and the conversion-done flag.
//   result channel : exactly one transfer per scan tick, in order: the debounced
//                    key (0 none, 1..8) and the wrapping count of tick periods.
//   cfg channel    : register writes by index (0 high level .. 6 ticks per period);
//                    always ready, indexes past the last register are dropped.
//                    Write only while no tick is in flight.
// Flow: an accepted tick goes into the lane registers, then into the result
//   register once that register is free.
// Throughput: one tick per cycle unless stalled. Lanes A, B average and compare
//   in the first stage; the merge stage classifies, debounces, updates counters.
// Stall: the result register holds while result_ready is low; the lane stage
//   still takes one more tick, then sample_ready drops until the result leaves.
// Reset: rst_n (async, active low) empties the pipeline, clears the debounce
//   and period state and restores every register to its default.
`timescale 1ns / 1ps
`default_nettype none
module analog_ladder_key_debouncer
    import ald_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire sample_t                sample_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_t                     result_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        lane_valid_reg;
    logic        lane_done_reg;
    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        out_free;
    logic        advance;
    logic        load;
    lane_flags_t flags_a;
    lane_flags_t flags_b;

    logic [SAMPLES_PER_CHANNEL-1:0][SAMPLE_W-1:0] samples_a;
    logic [SAMPLES_PER_CHANNEL-1:0][SAMPLE_W-1:0] samples_b;

    // Configuration registers; the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_level       <= RST_HIGH_LEVEL;
            cfg_reg.center_upper     <= RST_CENTER_UPPER;
            cfg_reg.center_middle    <= RST_CENTER_MIDDLE;
            cfg_reg.center_lower     <= RST_CENTER_LOWER;
            cfg_reg.window_half      <= RST_WINDOW_HALF;
            cfg_reg.hold_limit       <= RST_HOLD_LIMIT;
            cfg_reg.ticks_per_period <= RST_TICKS_PER_PERIOD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HIGH_LEVEL:       cfg_reg.high_level       <= cfg_data;
                REG_CENTER_UPPER:     cfg_reg.center_upper     <= cfg_data;
                REG_CENTER_MIDDLE:    cfg_reg.center_middle    <= cfg_data;
                REG_CENTER_LOWER:     cfg_reg.center_lower     <= cfg_data;
                REG_WINDOW_HALF:      cfg_reg.window_half      <= cfg_data[6:0];
                REG_HOLD_LIMIT:       cfg_reg.hold_limit       <= cfg_data;
                REG_TICKS_PER_PERIOD: cfg_reg.ticks_per_period <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Pipeline flow: advance the lane stage into the result register when it
    // is free or being drained; load the lane stage when it empties.
    assign out_free     = !result_valid_reg || result_ready;
    assign advance      = lane_valid_reg && out_free;
    assign sample_ready = !lane_valid_reg || out_free;
    assign load         = sample_valid && sample_ready;

    assign samples_a = {sample_data.sample_a4, sample_data.sample_a3, sample_data.sample_a2,
                        sample_data.sample_a1, sample_data.sample_a0};
    assign samples_b = {sample_data.sample_b4, sample_data.sample_b3, sample_data.sample_b2,
                        sample_data.sample_b1, sample_data.sample_b0};

    ald_lane u_lane_a
    (
        .clk     (clk),
        .load    (load),
        .samples (samples_a),
        .cfg     (cfg_reg),
        .flags   (flags_a)
    );

    ald_lane u_lane_b
    (
        .clk     (clk),
        .load    (load),
        .samples (samples_b),
        .cfg     (cfg_reg),
        .flags   (flags_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            lane_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            lane_valid_reg <= 1'b0;
        end
    end

    // Hold the conversion flag alongside the lane hits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_done_reg <= sample_data.conversion_done;
        end
    end

    ald_merge u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .conversion_done (lane_done_reg),
        .flags_a         (flags_a),
        .flags_b         (flags_b),
        .cfg             (cfg_reg),
        .result_next     (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
`default_nettype wire
